@@ rtl/core/amai_pkg.sv @@
`timescale 1ns / 1ps

package amai_pkg;

  localparam int W             = 32;
  localparam int THR_W         = 31;
  localparam int FRAC_BITS_DEF = 16;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  localparam logic [1:0] ROW_0 = 2'd0;
  localparam logic [1:0] ROW_1 = 2'd1;
  localparam logic [1:0] ROW_2 = 2'd2;

  typedef struct packed {
    logic [1:0] row;
    logic       last;
    logic       sing;
  } row_tag_t;

endpackage

@@ rtl/core/amai_if.sv @@
`timescale 1ns / 1ps

interface amai_in_if;
  import amai_pkg::*;

  logic                valid;
  logic                ready;
  logic signed [W-1:0] r0c0;
  logic signed [W-1:0] r0c1;
  logic signed [W-1:0] r0c2;
  logic signed [W-1:0] shift_x;
  logic signed [W-1:0] r1c0;
  logic signed [W-1:0] r1c1;
  logic signed [W-1:0] r1c2;
  logic signed [W-1:0] shift_y;
  logic signed [W-1:0] r2c0;
  logic signed [W-1:0] r2c1;
  logic signed [W-1:0] r2c2;
  logic signed [W-1:0] shift_z;

  modport source (output valid, r0c0, r0c1, r0c2, shift_x, r1c0, r1c1, r1c2, shift_y,
                  r2c0, r2c1, r2c2, shift_z, input ready);
  modport sink (input valid, r0c0, r0c1, r0c2, shift_x, r1c0, r1c1, r1c2, shift_y,
                r2c0, r2c1, r2c2, shift_z, output ready);
  modport mon (input valid, ready, r0c0, r0c1, r0c2, shift_x, r1c0, r1c1, r1c2, shift_y,
               r2c0, r2c1, r2c2, shift_z);
endinterface

interface amai_out_if;
  import amai_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          row_index;
  logic signed [W-1:0] col0;
  logic signed [W-1:0] col1;
  logic signed [W-1:0] col2;
  logic signed [W-1:0] col3;
  logic                singular;
  logic                last_row;

  modport source (output valid, row_index, col0, col1, col2, col3, singular, last_row,
                  input ready);
  modport sink (input valid, row_index, col0, col1, col2, col3, singular, last_row,
                output ready);
  modport mon (input valid, ready, row_index, col0, col1, col2, col3, singular, last_row);
endinterface

@@ rtl/core/affine_matrix_inverse.sv @@
`timescale 1ns / 1ps

// Inverts the 3x4 affine transform [L | t] and returns [L^-1 | -L^-1 t] as three
// rows of Q-format values, rounded half away from zero and saturated. A new
// matrix can be taken while the last row of the previous one is issued; its
// rows leave one per cycle unless the result stalls. The three rows share one
// row-serial datapath (cofactors, determinant, then four 32-step pipelined
// dividers), which sets the rate. When |det| falls below det_threshold (or det
// is zero) all rows carry singular set and zero values. A stalled result holds
// the whole pipeline.
module affine_matrix_inverse #(
  parameter int FRAC_BITS = amai_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [amai_pkg::THR_W-1:0] cfg_data,
  amai_in_if.sink                    matrix,
  amai_out_if.source                 inv_row
);
  import amai_pkg::*;

  localparam int CW  = 2 * W + 1;
  localparam int MW  = W + 1;
  localparam int PPW = W + MW;
  localparam int PW  = CW + W;
  localparam int SW  = PW + 2;
  localparam int NW  = SW + 2 * FRAC_BITS;
  localparam int TW  = $bits(row_tag_t);

  logic             en;
  logic             out_v;
  logic             acc;
  logic             hv;
  logic [1:0]       row;
  logic [THR_W-1:0] thr;

  logic signed [W-1:0] mx [9];
  logic signed [W-1:0] tv [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_data;
    end
  end

  assign en           = !out_v || inv_row.ready;
  assign matrix.ready = en && (!hv || row == ROW_2);
  assign acc          = matrix.valid && matrix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hv  <= 1'b0;
      row <= ROW_0;
    end else if (en) begin
      if (acc) begin
        hv  <= 1'b1;
        row <= ROW_0;
      end else if (hv) begin
        if (row == ROW_2) begin
          hv <= 1'b0;
        end else begin
          row <= row + 2'd1;
        end
      end
    end
    if (acc) begin
      mx[0] <= matrix.r0c0;
      mx[1] <= matrix.r0c1;
      mx[2] <= matrix.r0c2;
      mx[3] <= matrix.r1c0;
      mx[4] <= matrix.r1c1;
      mx[5] <= matrix.r1c2;
      mx[6] <= matrix.r2c0;
      mx[7] <= matrix.r2c1;
      mx[8] <= matrix.r2c2;
      tv[0] <= matrix.shift_x;
      tv[1] <= matrix.shift_y;
      tv[2] <= matrix.shift_z;
    end
  end

  // select the operands for one adjugate row: cof = p*q - r*s
  logic signed [W-1:0] op_p [3];
  logic signed [W-1:0] op_q [3];
  logic signed [W-1:0] op_r [3];
  logic signed [W-1:0] op_s [3];
  logic signed [W-1:0] op_m [3];

  always_comb begin
    case (row)
      ROW_0: begin
        op_p[0] = mx[4]; op_q[0] = mx[8]; op_r[0] = mx[5]; op_s[0] = mx[7];
        op_p[1] = mx[2]; op_q[1] = mx[7]; op_r[1] = mx[1]; op_s[1] = mx[8];
        op_p[2] = mx[1]; op_q[2] = mx[5]; op_r[2] = mx[2]; op_s[2] = mx[4];
        op_m[0] = mx[0]; op_m[1] = mx[3]; op_m[2] = mx[6];
      end
      ROW_1: begin
        op_p[0] = mx[5]; op_q[0] = mx[6]; op_r[0] = mx[3]; op_s[0] = mx[8];
        op_p[1] = mx[0]; op_q[1] = mx[8]; op_r[1] = mx[2]; op_s[1] = mx[6];
        op_p[2] = mx[2]; op_q[2] = mx[3]; op_r[2] = mx[0]; op_s[2] = mx[5];
        op_m[0] = mx[1]; op_m[1] = mx[4]; op_m[2] = mx[7];
      end
      default: begin
        op_p[0] = mx[3]; op_q[0] = mx[7]; op_r[0] = mx[4]; op_s[0] = mx[6];
        op_p[1] = mx[1]; op_q[1] = mx[6]; op_r[1] = mx[0]; op_s[1] = mx[7];
        op_p[2] = mx[0]; op_q[2] = mx[4]; op_r[2] = mx[1]; op_s[2] = mx[3];
        op_m[0] = mx[2]; op_m[1] = mx[5]; op_m[2] = mx[8];
      end
    endcase
  end

  logic     s1_v, s2_v, s3_v, s4_v, s5_v, s6_v;
  row_tag_t s1_tag, s2_tag, s3_tag, s4_tag, s5_tag, s6_tag;

  logic signed [2*W-1:0] s1_pp [3];
  logic signed [2*W-1:0] s1_pn [3];
  logic signed [W-1:0]   s1_m  [3];
  logic signed [W-1:0]   s1_t  [3];

  logic signed [CW-1:0]  s2_cof [3];
  logic signed [W-1:0]   s2_m   [3];
  logic signed [W-1:0]   s2_t   [3];

  logic signed [PPW-1:0] s3_mlo [3];
  logic signed [PPW-1:0] s3_mhi [3];
  logic signed [PPW-1:0] s3_tlo [3];
  logic signed [PPW-1:0] s3_thi [3];
  logic signed [CW-1:0]  s3_cof [3];

  logic signed [PW-1:0]  s4_mp  [3];
  logic signed [PW-1:0]  s4_tp  [3];
  logic signed [CW-1:0]  s4_cof [3];

  logic signed [SW-1:0]  s5_det;
  logic signed [SW-1:0]  s5_acc;
  logic signed [CW-1:0]  s5_cof [3];

  logic [NW-1:0] s6_num [4];
  logic          s6_sgn [4];
  logic [SW-1:0] s6_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
      s6_v <= 1'b0;
    end else if (en) begin
      s1_v <= hv;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
      s6_v <= s5_v;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    logic signed [MW-1:0] lo;
    logic signed [MW-1:0] hi;

    assign lo = $signed({1'b0, s2_cof[k][W-1:0]});
    assign hi = s2_cof[k][CW-1:W];

    always_ff @(posedge clk) begin
      if (en) begin
        s1_pp[k]  <= (2*W)'(op_p[k]) * (2*W)'(op_q[k]);
        s1_pn[k]  <= (2*W)'(op_r[k]) * (2*W)'(op_s[k]);
        s1_m[k]   <= op_m[k];
        s1_t[k]   <= tv[k];
        s2_cof[k] <= CW'(s1_pp[k]) - CW'(s1_pn[k]);
        s2_m[k]   <= s1_m[k];
        s2_t[k]   <= s1_t[k];
        s3_mlo[k] <= PPW'(s2_m[k]) * PPW'(lo);
        s3_mhi[k] <= PPW'(s2_m[k]) * PPW'(hi);
        s3_tlo[k] <= PPW'(s2_t[k]) * PPW'(lo);
        s3_thi[k] <= PPW'(s2_t[k]) * PPW'(hi);
        s3_cof[k] <= s2_cof[k];
        s4_mp[k]  <= (PW'(s3_mhi[k]) <<< W) + PW'(s3_mlo[k]);
        s4_tp[k]  <= (PW'(s3_thi[k]) <<< W) + PW'(s3_tlo[k]);
        s4_cof[k] <= s3_cof[k];
        s5_cof[k] <= s4_cof[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag <= '{row: row, last: (row == ROW_2), sing: 1'b0};
      s2_tag <= s1_tag;
      s3_tag <= s2_tag;
      s4_tag <= s3_tag;
      s5_tag <= s4_tag;
      s5_det <= SW'(s4_mp[0]) + SW'(s4_mp[1]) + SW'(s4_mp[2]);
      s5_acc <= SW'(s4_tp[0]) + SW'(s4_tp[1]) + SW'(s4_tp[2]);
    end
  end

  logic          det_neg;
  logic          acc_neg;
  logic [SW-1:0] det_abs;
  logic [SW-1:0] acc_abs;
  logic [SW-1:0] thr_x;
  logic          sing;
  logic [CW-1:0] cof_abs [3];

  always_comb begin
    det_neg = s5_det[SW-1];
    acc_neg = s5_acc[SW-1];
    det_abs = det_neg ? SW'(-s5_det) : SW'(s5_det);
    acc_abs = acc_neg ? SW'(-s5_acc) : SW'(s5_acc);
    thr_x   = SW'(thr) << (2 * FRAC_BITS);
    sing    = (s5_det == '0) || (det_abs < thr_x);
    for (int k = 0; k < 3; k++) begin
      cof_abs[k] = s5_cof[k][CW-1] ? CW'(-s5_cof[k]) : CW'(s5_cof[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s6_num[k] <= NW'(cof_abs[k]) << (2 * FRAC_BITS);
        s6_sgn[k] <= s5_cof[k][CW-1] ^ det_neg;
      end
      s6_num[3] <= NW'(acc_abs) << FRAC_BITS;
      s6_sgn[3] <= !acc_neg ^ det_neg;
      s6_den    <= det_abs;
      s6_tag    <= '{row: s5_tag.row, last: s5_tag.last, sing: sing};
    end
  end

  logic          dv   [4];
  logic [W-1:0]  dres [4];
  logic [TW-1:0] dtag [4];
  row_tag_t      otag;

  for (genvar k = 0; k < 4; k++) begin : g_div
    amai_div #(
      .NW (NW),
      .DW (SW),
      .QW (W),
      .TW (TW)
    ) u_div (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .in_v       (s6_v),
      .num        (s6_num[k]),
      .den        (s6_den),
      .neg        (s6_sgn[k]),
      .force_zero (s6_tag.sing),
      .tag_in     (s6_tag),
      .out_v      (dv[k]),
      .res        (dres[k]),
      .tag_out    (dtag[k])
    );
  end

  assign out_v = dv[0];
  assign otag  = row_tag_t'(dtag[0]);

  assign inv_row.valid     = out_v;
  assign inv_row.row_index = otag.row;
  assign inv_row.singular  = otag.sing;
  assign inv_row.last_row  = otag.last;
  assign inv_row.col0      = dres[0];
  assign inv_row.col1      = dres[1];
  assign inv_row.col2      = dres[2];
  assign inv_row.col3      = dres[3];

endmodule

@@ rtl/core/amai_div.sv @@
`timescale 1ns / 1ps

module amai_div #(
  parameter int NW = 131,
  parameter int DW = 99,
  parameter int QW = amai_pkg::W,
  parameter int TW = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          neg,
  input  logic          force_zero,
  input  logic [TW-1:0] tag_in,
  output logic          out_v,
  output logic [QW-1:0] res,
  output logic [TW-1:0] tag_out
);

  localparam int RW = DW + QW;
  localparam int XW = (NW > RW) ? NW : RW;

  logic          v   [QW+1];
  logic [RW-1:0] rm  [QW+1];
  logic [QW-1:0] quo [QW+1];
  logic [DW-1:0] dd  [QW+1];
  logic          ng  [QW+1];
  logic          zr  [QW+1];
  logic          ovf [QW+1];
  logic [TW-1:0] tg  [QW+1];

  logic [XW-1:0] num_x;
  logic [XW-1:0] lim_x;

  assign num_x = XW'(num);
  assign lim_x = XW'({den, {QW{1'b0}}});

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
    end
    if (en) begin
      rm[0]  <= num_x[RW-1:0];
      quo[0] <= '0;
      dd[0]  <= den;
      ng[0]  <= neg;
      zr[0]  <= force_zero;
      ovf[0] <= (num_x >= lim_x);
      tg[0]  <= tag_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    localparam int B = QW - k;
    logic [RW:0]   diff;
    logic [RW-1:0] dsh;

    assign dsh  = RW'(dd[k-1]) << B;
    assign diff = {1'b0, rm[k-1]} - {1'b0, dsh};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k] <= 1'b0;
      end else if (en) begin
        v[k] <= v[k-1];
      end
      if (en) begin
        rm[k]  <= diff[RW] ? rm[k-1] : diff[RW-1:0];
        quo[k] <= quo[k-1] | (QW'(!diff[RW]) << B);
        dd[k]  <= dd[k-1];
        ng[k]  <= ng[k-1];
        zr[k]  <= zr[k-1];
        ovf[k] <= ovf[k-1];
        tg[k]  <= tg[k-1];
      end
    end
  end

  logic          rnd;
  logic [QW:0]   mag;
  logic [QW:0]   lim;
  logic [QW:0]   mag_sat;
  logic [QW-1:0] res_next;

  always_comb begin
    rnd      = ({rm[QW][DW-1:0], 1'b0} >= {1'b0, dd[QW]});
    mag      = {1'b0, quo[QW]} + (QW+1)'(rnd);
    lim      = ng[QW] ? ((QW+1)'(1) << (QW-1)) : (((QW+1)'(1) << (QW-1)) - (QW+1)'(1));
    mag_sat  = (ovf[QW] || (mag > lim)) ? lim : mag;
    res_next = zr[QW] ? '0 : (ng[QW] ? -mag_sat[QW-1:0] : mag_sat[QW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= v[QW];
    end
    if (en) begin
      res     <= res_next;
      tag_out <= tg[QW];
    end
  end

endmodule

@@ rtl/core/amai_check.sv @@
`timescale 1ns / 1ps

module amai_check (
  input logic                     clk,
  input logic                     rst,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [1:0]               row_index,
  input logic [amai_pkg::W-1:0]   col0,
  input logic [amai_pkg::W-1:0]   col1,
  input logic [amai_pkg::W-1:0]   col2,
  input logic [amai_pkg::W-1:0]   col3,
  input logic                     singular,
  input logic                     last_row
);
  import amai_pkg::*;

  logic [1:0] row_exp;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_exp <= ROW_0;
    end else if (out_valid && out_ready) begin
      row_exp <= last_row ? ROW_0 : row_exp + 2'd1;
    end
  end

  a_row_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_index == row_exp)
    else $error("result rows out of order");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> last_row == (row_index == ROW_2))
    else $error("last_row does not match row_index");

  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && singular |->
      col0 == '0 && col1 == '0 && col2 == '0 && col3 == '0)
    else $error("singular row carries nonzero values");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while result stalled");

endmodule

bind affine_matrix_inverse amai_check u_amai_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (matrix.ready),
  .out_valid (inv_row.valid),
  .out_ready (inv_row.ready),
  .row_index (inv_row.row_index),
  .col0      (inv_row.col0),
  .col1      (inv_row.col1),
  .col2      (inv_row.col2),
  .col3      (inv_row.col3),
  .singular  (inv_row.singular),
  .last_row  (inv_row.last_row)
);
